FILE: hdl/upd_pkg.sv
// Shared types and codes for the UDP port demux table.
`timescale 1ns / 1ps

package upd_pkg;

  typedef enum logic [1:0] {
    OP_BIND   = 2'd0,
    OP_UNBIND = 2'd1,
    OP_RECV   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_SHORT     = 3'd3,
    ST_UNBOUND   = 3'd4
  } status_e;

  localparam logic [15:0] HDR_BYTES = 16'd8;

  // Command word walking down the cell chain, with the answer built so far.
  typedef struct packed {
    logic        vld;
    op_e         op;
    logic [15:0] port;
    logic [3:0]  hid;
    logic        done;
    status_e     status;
    logic [3:0]  handler;
    logic [2:0]  slot;
  } tok_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  handler;
    logic [15:0] sport;
    logic [15:0] pay_len;
    logic [2:0]  slot;
  } rsp_t;

endpackage

FILE: hdl/upd_if.sv
// Request and response channel interfaces of the UDP port demux table.
`timescale 1ns / 1ps

interface upd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] port;
  logic [3:0]  handler_id;
  logic [15:0] available_length;
  logic [15:0] source_port;
  logic [15:0] length_field;

  modport source (output valid, operation, port, handler_id, available_length,
                  source_port, length_field, input ready);
  modport sink (input valid, operation, port, handler_id, available_length,
                source_port, length_field, output ready);
endinterface

interface upd_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  delivered_handler;
  logic [15:0] delivered_source_port;
  logic [15:0] payload_length;
  logic [2:0]  slot_index;

  modport source (output valid, status, delivered_handler, delivered_source_port,
                  payload_length, slot_index, input ready);
  modport sink (input valid, status, delivered_handler, delivered_source_port,
                payload_length, slot_index, output ready);
endinterface

FILE: hdl/udp_port_demux_table.sv
// UDP port demux table: a chain of binding cells walked by each command word.
// A word passes every cell, then a hold register and the output register; it visits
// one cell per cycle. A new word is taken once the last result has left the hold
// register, so a finished result may wait on the output while the next word walks.
// Reset (async, active low) clears all bindings and empties the pipeline.
`timescale 1ns / 1ps

module udp_port_demux_table #(
  parameter int SLOTS        = 8,
  parameter int HANDLER_BITS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_req_if.sink   req_i,
  upd_rsp_if.source rsp_o
);

  upd_pkg::tok_t  tok [SLOTS+1];
  upd_pkg::op_e   op_in;
  logic           accept;
  logic           short_hdr;
  logic           busy_q;
  logic           hold_v_q, out_v_q;
  logic           hold_take;
  logic [15:0]    sport_q, lenf_q;
  upd_pkg::rsp_t  hold_q, out_q;
  upd_pkg::rsp_t  fin;

  assign op_in     = upd_pkg::op_e'(req_i.operation);
  assign req_i.ready = !busy_q;
  assign accept    = req_i.valid && !busy_q;
  assign short_hdr = (req_i.available_length < upd_pkg::HDR_BYTES);

  always_comb begin
    tok[0]         = '0;
    tok[0].vld     = accept;
    tok[0].op      = op_in;
    tok[0].port    = req_i.port;
    tok[0].hid     = req_i.handler_id;
    tok[0].handler = '0;
    tok[0].slot    = '0;
    unique case (op_in)
      upd_pkg::OP_BIND: begin
        tok[0].done   = 1'b0;
        tok[0].status = upd_pkg::ST_FULL;
      end
      upd_pkg::OP_RECV: begin
        tok[0].done   = short_hdr;
        tok[0].status = short_hdr ? upd_pkg::ST_SHORT : upd_pkg::ST_UNBOUND;
      end
      default: begin
        tok[0].done   = 1'b1;
        tok[0].status = upd_pkg::ST_OK;
      end
    endcase
  end

  for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
    upd_cell #(
      .HANDLER_BITS(HANDLER_BITS),
      .SLOT_IDX    (gi)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[gi]),
      .tok_o (tok[gi+1])
    );
  end

  // fill in datagram fields once the word leaves the chain
  always_comb begin
    fin.status  = tok[SLOTS].status;
    fin.handler = tok[SLOTS].handler;
    fin.slot    = tok[SLOTS].slot;
    if (tok[SLOTS].status == upd_pkg::ST_DELIVERED) begin
      fin.sport   = sport_q;
      fin.pay_len = lenf_q - upd_pkg::HDR_BYTES;
    end else begin
      fin.sport   = '0;
      fin.pay_len = '0;
    end
  end

  assign hold_take = hold_v_q && (!out_v_q || rsp_o.ready);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sport_q <= req_i.source_port;
      lenf_q  <= req_i.length_field;
    end
    if (tok[SLOTS].vld) begin
      hold_q <= fin;
    end
    if (hold_take) begin
      out_q <= hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (hold_take) begin
        busy_q <= 1'b0;
      end
      if (tok[SLOTS].vld) begin
        hold_v_q <= 1'b1;
      end else if (hold_take) begin
        hold_v_q <= 1'b0;
      end
      if (hold_take) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid                 = out_v_q;
  assign rsp_o.status                = out_q.status;
  assign rsp_o.delivered_handler     = out_q.handler;
  assign rsp_o.delivered_source_port = out_q.sport;
  assign rsp_o.payload_length        = out_q.pay_len;
  assign rsp_o.slot_index            = out_q.slot;

endmodule

FILE: hdl/upd_cell.sv
// One table slot: holds a binding and acts on the command word passing by.
`timescale 1ns / 1ps

module upd_cell #(
  parameter int HANDLER_BITS = 4,
  parameter int SLOT_IDX     = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  upd_pkg::tok_t tok_i,
  output upd_pkg::tok_t tok_o
);

  localparam logic [2:0] SlotCode = 3'(SLOT_IDX);

  logic                    valid_q, valid_d;
  logic [15:0]             port_q, port_d;
  logic [HANDLER_BITS-1:0] hid_q, hid_d;
  upd_pkg::tok_t           tok_q, tok_d;
  logic                    match;

  assign match = (port_q == tok_i.port);

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    port_d  = port_q;
    hid_d   = hid_q;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        upd_pkg::OP_BIND: begin
          // first empty slot or same port claims the bind
          if (!tok_i.done && (!valid_q || match)) begin
            valid_d      = 1'b1;
            port_d       = tok_i.port;
            hid_d        = HANDLER_BITS'(tok_i.hid);
            tok_d.done   = 1'b1;
            tok_d.status = upd_pkg::ST_OK;
            tok_d.slot   = SlotCode;
          end
        end
        upd_pkg::OP_UNBIND: begin
          // clear on port match, valid or not
          if (match) begin
            valid_d = 1'b0;
            port_d  = '0;
            hid_d   = '0;
          end
        end
        upd_pkg::OP_RECV: begin
          if (!tok_i.done && valid_q && match) begin
            tok_d.done    = 1'b1;
            tok_d.status  = upd_pkg::ST_DELIVERED;
            tok_d.handler = 4'(hid_q);
            tok_d.slot    = SlotCode;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      port_q  <= '0;
      hid_q   <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      port_q  <= port_d;
      hid_q   <= hid_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: hdl/upd_checker.sv
// Port-level checks for the UDP port demux table, bound to the top level.
`timescale 1ns / 1ps

module upd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  status_i,
  input logic [3:0]  handler_i,
  input logic [15:0] sport_i,
  input logic [15:0] pay_len_i,
  input logic [2:0]  slot_i
);

  // a stalled response word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(slot_i)
      && $stable(handler_i) && $stable(sport_i) && $stable(pay_len_i))
    else $error("response changed while stalled");

  // one word at a time: no new word right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous word in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> status_i == upd_pkg::ST_OK || status_i == upd_pkg::ST_FULL
      || status_i == upd_pkg::ST_DELIVERED || status_i == upd_pkg::ST_SHORT
      || status_i == upd_pkg::ST_UNBOUND)
    else $error("undefined status code");

  // only a delivery carries datagram fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != upd_pkg::ST_DELIVERED
      |-> handler_i == 4'd0 && sport_i == 16'd0 && pay_len_i == 16'd0)
    else $error("non-delivery response carries datagram fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != upd_pkg::ST_DELIVERED && status_i != upd_pkg::ST_OK
      |-> slot_i == 3'd0)
    else $error("failed operation reports a slot");

endmodule

bind udp_port_demux_table upd_checker u_upd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .status_i   (rsp_o.status),
  .handler_i  (rsp_o.delivered_handler),
  .sport_i    (rsp_o.delivered_source_port),
  .pay_len_i  (rsp_o.payload_length),
  .slot_i     (rsp_o.slot_index)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the UDP port demux table: directed, then random command words.
`timescale 1ns / 1ps

localparam int TABLE_SLOTS = 8;

typedef struct {
  upd_pkg::op_e op;
  logic [15:0]  port;
  logic [3:0]   hid;
  logic [15:0]  avail;
  logic [15:0]  sport;
  logic [15:0]  lenf;
} cmd_word_t;

class port_table_sb;
  logic          bound[TABLE_SLOTS];
  logic [15:0]   bound_port[TABLE_SLOTS];
  logic [3:0]    bound_hid[TABLE_SLOTS];
  upd_pkg::rsp_t pending_answers[$];
  int            errors;

  function new();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      bound[i] = 1'b0;
      bound_port[i] = '0;
      bound_hid[i] = '0;
    end
    errors = 0;
  endfunction

  // Update the binding table and return the answer the word should get.
  function upd_pkg::rsp_t apply_word(cmd_word_t w);
    upd_pkg::rsp_t a;
    a = '0;
    a.status = upd_pkg::ST_OK;
    case (w.op)
      upd_pkg::OP_BIND: begin
        a.status = upd_pkg::ST_FULL;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!bound[i] || bound_port[i] == w.port) begin
            bound[i] = 1'b1;
            bound_port[i] = w.port;
            bound_hid[i] = w.hid;
            a.status = upd_pkg::ST_OK;
            a.slot = 3'(i);
            break;
          end
        end
      end
      upd_pkg::OP_UNBIND: begin
        // Clear on port match alone, valid or not.
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (bound_port[i] == w.port) begin
            bound[i] = 1'b0;
            bound_port[i] = '0;
            bound_hid[i] = '0;
          end
        end
      end
      upd_pkg::OP_RECV: begin
        if (w.avail < upd_pkg::HDR_BYTES) begin
          a.status = upd_pkg::ST_SHORT;
        end else begin
          a.status = upd_pkg::ST_UNBOUND;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (bound[i] && bound_port[i] == w.port) begin
              a.status = upd_pkg::ST_DELIVERED;
              a.handler = bound_hid[i];
              a.sport = w.sport;
              a.pay_len = w.lenf - upd_pkg::HDR_BYTES;
              a.slot = 3'(i);
              break;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function void note_word(cmd_word_t w);
    pending_answers.push_back(apply_word(w));
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
      errors++;
    end
  endfunction

  function void check_answer(upd_pkg::rsp_t got);
    upd_pkg::rsp_t want;
    if (pending_answers.size() == 0) begin
      $display("%0t: result expected none got status %0h", $time, got.status);
      errors++;
      return;
    end
    want = pending_answers.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("handler", want.handler, got.handler);
    compare_field("source_port", want.sport, got.sport);
    compare_field("payload_length", want.pay_len, got.pay_len);
    compare_field("slot_index", want.slot, got.slot);
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 850;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int   cycle_count;
  int   hold_left;

  upd_req_if req_ch();
  upd_rsp_if rsp_ch();

  port_table_sb sb;

  logic [15:0] port_pool[12] = '{16'd0, 16'd1, 16'd7, 16'd53, 16'd80, 16'd123, 16'd443,
                                 16'd1024, 16'h1234, 16'd8080, 16'h8000, 16'hFFFF};

  udp_port_demux_table #(
    .SLOTS(TABLE_SLOTS),
    .HANDLER_BITS(4)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Mostly no wait, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Result side: check each word taken, then stall at random.
  always @(posedge clk_i) begin
    upd_pkg::rsp_t got;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = upd_pkg::status_e'(rsp_ch.status);
        got.handler = rsp_ch.delivered_handler;
        got.sport = rsp_ch.delivered_source_port;
        got.pay_len = rsp_ch.payload_length;
        got.slot = rsp_ch.slot_index;
        sb.check_answer(got);
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        hold_left = pick_gap();
      end
    end
  end

  task automatic send_word(cmd_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= w.op;
    req_ch.port <= w.port;
    req_ch.handler_id <= w.hid;
    req_ch.available_length <= w.avail;
    req_ch.source_port <= w.sport;
    req_ch.length_field <= w.lenf;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_word(w);
  endtask

  task automatic issue(upd_pkg::op_e op, logic [15:0] port, logic [3:0] hid,
                       logic [15:0] avail, logic [15:0] sport, logic [15:0] lenf);
    cmd_word_t w;
    w.op = op;
    w.port = port;
    w.hid = hid;
    w.avail = avail;
    w.sport = sport;
    w.lenf = lenf;
    send_word(w);
  endtask

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) w.op = upd_pkg::OP_BIND;
    else if (r < 55) w.op = upd_pkg::OP_UNBIND;
    else if (r < 95) w.op = upd_pkg::OP_RECV;
    else w.op = upd_pkg::OP_NONE;
    // Reuse a few ports so binds, unbinds and receives meet.
    if ($urandom_range(0, 99) < 80) w.port = port_pool[$urandom_range(0, 11)];
    else w.port = 16'($urandom);
    w.hid = 4'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) w.avail = 16'($urandom_range(0, 7));
    else if (r < 15) w.avail = 16'd8;
    else w.avail = 16'($urandom);
    if (w.avail < upd_pkg::HDR_BYTES && r >= 10) w.avail = 16'($urandom_range(8, 65535));
    w.sport = 16'($urandom);
    if ($urandom_range(0, 99) < 20) w.lenf = 16'($urandom_range(0, 9));
    else w.lenf = 16'($urandom);
    return w;
  endfunction

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    quiet = 1'b0;
    cycle_count = 0;
    hold_left = 0;
    req_ch.valid = 1'b0;
    req_ch.operation = upd_pkg::OP_NONE;
    req_ch.port = '0;
    req_ch.handler_id = '0;
    req_ch.available_length = '0;
    req_ch.source_port = '0;
    req_ch.length_field = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, short headers, boundary length.
    issue(upd_pkg::OP_RECV, 16'd80, 4'h0, 16'd100, 16'd1234, 16'd20);
    issue(upd_pkg::OP_RECV, 16'd80, 4'h0, 16'd0, 16'hFFFF, 16'hFFFF);
    issue(upd_pkg::OP_RECV, 16'd80, 4'h0, 16'd7, 16'd1, 16'd30);
    // Handler zero is a real binding; extremes of port and handler.
    issue(upd_pkg::OP_BIND, 16'd0, 4'h0, 16'd0, 16'd0, 16'd0);
    issue(upd_pkg::OP_BIND, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(upd_pkg::OP_RECV, 16'd0, 4'h0, 16'd8, 16'hFFFF, 16'd0);
    issue(upd_pkg::OP_RECV, 16'hFFFF, 4'hF, 16'hFFFF, 16'd0, 16'd8);
    issue(upd_pkg::OP_RECV, 16'hFFFF, 4'h0, 16'hFFFF, 16'h5555, 16'hFFFF);
    // Rebind reuses the slot.
    issue(upd_pkg::OP_BIND, 16'hFFFF, 4'h5, 16'd0, 16'd0, 16'd0);
    for (int i = 1; i <= 6; i++) begin
      issue(upd_pkg::OP_BIND, 16'(i), 4'(i), 16'd0, 16'd0, 16'd0);
    end
    issue(upd_pkg::OP_BIND, 16'd7, 4'h7, 16'd0, 16'd0, 16'd0);
    // Full table still accepts a port it already holds.
    issue(upd_pkg::OP_BIND, 16'd3, 4'hA, 16'd0, 16'd0, 16'd0);
    issue(upd_pkg::OP_UNBIND, 16'd0, 4'h0, 16'd0, 16'd0, 16'd0);
    // Earlier empty slot wins: port 5 ends up twice.
    issue(upd_pkg::OP_BIND, 16'd5, 4'hC, 16'd0, 16'd0, 16'd0);
    issue(upd_pkg::OP_RECV, 16'd5, 4'h0, 16'd64, 16'hA5A5, 16'd64);
    issue(upd_pkg::OP_UNBIND, 16'd5, 4'h0, 16'd0, 16'd0, 16'd0);
    issue(upd_pkg::OP_RECV, 16'd5, 4'h0, 16'd64, 16'h5A5A, 16'd64);
    issue(upd_pkg::OP_NONE, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(upd_pkg::OP_UNBIND, 16'd999, 4'h0, 16'd0, 16'd0, 16'd0);
    issue(upd_pkg::OP_RECV, 16'd7, 4'h0, 16'd8, 16'd2, 16'd9);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(random_word());
    end
    req_ch.valid <= 1'b0;
    quiet = 1'b1;

    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (TABLE_SLOTS + 6) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/upd_pkg.sv
hdl/upd_if.sv
hdl/upd_cell.sv
hdl/udp_port_demux_table.sv
hdl/upd_checker.sv
tb/tb_top.sv
